// ===== hdl/macp_pkg.sv =====
// Package for the MAC address text parser: widths, character codes,
// string positions and the hex digit decoder. No dependencies.
package macp_pkg;

    localparam int ADDR_W   = 48;
    localparam int POS_W    = 5;
    localparam int NIBBLE_W = 4;

    typedef logic [7:0]          t_char;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [NIBBLE_W-1:0] t_nibble;

    // string lengths and the saturation point of the position count
    localparam t_pos LEN_PLAIN  = t_pos'(12);
    localparam t_pos LEN_JOINED = t_pos'(17);
    localparam t_pos POS_MAX    = t_pos'(31);

    // positions in the joined form
    localparam t_pos POS_FIRST_SEP = t_pos'(2);
    localparam t_pos POS_SEP_B     = t_pos'(5);
    localparam t_pos POS_SEP_C     = t_pos'(8);
    localparam t_pos POS_SEP_D     = t_pos'(11);
    localparam t_pos POS_SEP_E     = t_pos'(14);

    localparam t_char CHAR_COLON = 8'h3A;
    localparam t_char CHAR_DASH  = 8'h2D;
    localparam t_char CHAR_0     = 8'h30;
    localparam t_char CHAR_9     = 8'h39;
    localparam t_char CHAR_LC_A  = 8'h61;
    localparam t_char CHAR_LC_F  = 8'h66;
    localparam t_char CHAR_UC_A  = 8'h41;
    localparam t_char CHAR_UC_F  = 8'h46;

    typedef struct packed {
        logic    ok;
        t_nibble value;
    } t_hex;

    // decode one ASCII hex digit, either case
    function automatic t_hex hex_decode(input t_char c);
        t_hex   h;
        t_char  d;
        h = '{ok: 1'b0, value: '0};
        d = '0;
        priority if (c >= CHAR_0 && c <= CHAR_9) begin
            d = c - CHAR_0;
            h = '{ok: 1'b1, value: d[NIBBLE_W-1:0]};
        end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
            d = c - CHAR_LC_A + 8'd10;
            h = '{ok: 1'b1, value: d[NIBBLE_W-1:0]};
        end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
            d = c - CHAR_UC_A + 8'd10;
            h = '{ok: 1'b1, value: d[NIBBLE_W-1:0]};
        end else begin
            h = '{ok: 1'b0, value: '0};
        end
        return h;
    endfunction

endpackage

// ===== hdl/macp_if.sv =====
// Channel interfaces for the MAC address text parser: character beats in,
// address beats out. Depends on macp_pkg.
interface macp_char_if;
    import macp_pkg::*;
    logic  valid;
    logic  ready;
    t_char char_code;
    logic  last_char;
    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface macp_addr_if;
    import macp_pkg::*;
    logic  valid;
    logic  ready;
    t_addr address;
    logic  valid_res;
    modport source (output valid, output address, output valid_res, input ready);
    modport sink   (input valid, input address, input valid_res, output ready);
endinterface

// ===== hdl/mac_address_text_parser.sv =====
// MAC address text parser, top level. Depends on macp_pkg and the channel
// interfaces in macp_if.sv.
//
// Usage:
//   i_char carries one ASCII character per beat, with last_char set on the
//   final character of a string. Accepted forms: twelve hex digits, or six
//   hex pairs joined by ':' or '-' (same separator throughout).
//   o_addr carries one beat per string, issued for the last character:
//   address (first byte in bits 47:40) and valid_res. A malformed string
//   gives valid_res 0 and address 0.
// Timing:
//   One character per cycle while i_char.ready is high. Each character
//   updates the parse state in the cycle it is accepted; the result of a last
//   character goes to the output register, or to the skid entry (the only
//   other slot) when a stalled result holds the output register, so input
//   keeps flowing while a result waits. i_char.ready drops only when both
//   are full, i.e. two results are waiting on a stalled receiver.
// Reset:
//   Synchronous, active low. Clears the parse state and both output slots;
//   the parser restarts at the first character of a new string. After each
//   last character the parse state returns to its reset value.
module mac_address_text_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    macp_char_if.sink         i_char,
    macp_addr_if.source       o_addr
);
    import macp_pkg::*;

    // parse state
    t_pos  r_position;
    t_addr r_accum;
    logic  r_sep_form;
    logic  r_sep_dash;
    logic  r_error;

    t_pos  n_position;
    t_addr n_accum;
    logic  n_sep_form;
    logic  n_sep_dash;
    logic  n_error;

    // output slots
    logic  r_out_valid;
    t_addr r_out_addr;
    logic  r_out_ok;
    logic  r_skid_valid;
    t_addr r_skid_addr;
    logic  r_skid_ok;

    logic  in_beat;
    logic  out_beat;
    logic  push;
    logic  res_ok;
    t_addr res_addr;
    logic  is_sep_char;
    logic  sep_slot;
    t_char sep_want;
    t_hex  hex;

    assign in_beat  = i_char.valid && i_char.ready;
    assign out_beat = r_out_valid && o_addr.ready;
    assign push     = in_beat && i_char.last_char;

    // ready only depends on the skid slot: a new result can always go to the
    // result register or, while that one is stalled, to the empty skid entry
    assign i_char.ready = !r_skid_valid;

    assign is_sep_char = (i_char.char_code == CHAR_COLON) || (i_char.char_code == CHAR_DASH);
    assign sep_slot    = r_sep_form && ((r_position == POS_SEP_B) || (r_position == POS_SEP_C)
                                     || (r_position == POS_SEP_D) || (r_position == POS_SEP_E));
    assign sep_want    = r_sep_dash ? CHAR_DASH : CHAR_COLON;
    assign hex         = hex_decode(i_char.char_code);

    // per-character update, before the end-of-string check
    always_comb begin
        n_accum    = r_accum;
        n_sep_form = r_sep_form;
        n_sep_dash = r_sep_dash;
        n_error    = r_error;
        priority if (r_position == POS_FIRST_SEP && is_sep_char) begin
            // the third character picks the joined form and its separator
            n_sep_form = 1'b1;
            n_sep_dash = (i_char.char_code == CHAR_DASH);
        end else if (r_position < LEN_JOINED) begin
            if (sep_slot) begin
                if (i_char.char_code != sep_want) begin
                    n_error = 1'b1;
                end
            end else if (hex.ok) begin
                n_accum = {r_accum[ADDR_W-NIBBLE_W-1:0], hex.value};
            end else begin
                n_error = 1'b1;
            end
        end else begin
            // past the longest form: characters go unchecked
            n_error = r_error;
        end
    end

    // length check on the last character; r_position is its index
    always_comb begin
        res_ok   = !n_error && ((!n_sep_form && r_position == LEN_PLAIN - t_pos'(1))
                             || (n_sep_form && r_position == LEN_JOINED - t_pos'(1)));
        res_addr = res_ok ? n_accum : '0;
        n_position = (r_position == POS_MAX) ? r_position : r_position + t_pos'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_accum    <= '0;
            r_sep_form <= 1'b0;
            r_sep_dash <= 1'b0;
            r_error    <= 1'b0;
        end else if (in_beat) begin
            if (i_char.last_char) begin
                r_position <= '0;
                r_accum    <= '0;
                r_sep_form <= 1'b0;
                r_sep_dash <= 1'b0;
                r_error    <= 1'b0;
            end else begin
                r_position <= n_position;
                r_accum    <= n_accum;
                r_sep_form <= n_sep_form;
                r_sep_dash <= n_sep_dash;
                r_error    <= n_error;
            end
        end
    end

    // result register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (push) begin
                if (!r_out_valid || out_beat) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_beat) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            if (!r_out_valid || out_beat) begin
                r_out_addr <= res_addr;
                r_out_ok   <= res_ok;
            end else begin
                r_skid_addr <= res_addr;
                r_skid_ok   <= res_ok;
            end
        end else if (out_beat) begin
            r_out_addr <= r_skid_addr;
            r_out_ok   <= r_skid_ok;
        end
    end

    assign o_addr.valid     = r_out_valid;
    assign o_addr.address   = r_out_addr;
    assign o_addr.valid_res = r_out_ok;

endmodule

// ===== hdl/macp_checker.sv =====
// Port-level checks for the MAC address text parser, bound to the top
// level. Depends on macp_pkg.
module macp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_in_last,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input macp_pkg::t_addr i_out_address,
    input logic           i_out_valid_res
);
    import macp_pkg::*;

    // a rejected string always reports a zero address
    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_valid_res) |-> (i_out_address == '0))
        else $error("invalid result with nonzero address");

    // a new result only follows an accepted last character
    a_result_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last))
        else $error("result without a last character");

    // reset empties the output side
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_address) && $stable(i_out_valid_res)))
        else $error("stalled result changed");

endmodule

bind mac_address_text_parser macp_checker u_macp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_char.valid),
    .i_in_ready      (i_char.ready),
    .i_in_last       (i_char.last_char),
    .i_out_valid     (o_addr.valid),
    .i_out_ready     (o_addr.ready),
    .i_out_address   (o_addr.address),
    .i_out_valid_res (o_addr.valid_res)
);

// ===== tb/tb.sv =====
// Testbench for mac_address_text_parser: a table of directed strings, then
// random address strings, checked beat by beat against a local parser model
// or a typed row's own result. Depends on macp_pkg, macp_if.sv and the parser RTL.
module tb;
    import macp_pkg::*;

    localparam int ITEM_TARGET = 1650;  // character beats to send, directed ones included
    localparam int IDLE_LIMIT  = 2000;  // cycles with no beat on either side
    localparam int DRAIN_WAIT  = 4;     // settle time after the last result
    localparam int N_DIR       = 23;

    typedef t_char t_char_q[$];

    // one beat on the address channel
    typedef struct packed {
        t_addr address;
        logic  valid_res;
    } t_addr_beat;

    // directed string; typed rows carry their expected result
    typedef struct {
        string text;
        bit    typed;
        t_addr address;
        logic  valid_res;
    } t_dir_case;

    logic i_clk;
    logic i_rst_n;

    macp_char_if char_ch ();
    macp_addr_if addr_ch ();

    mac_address_text_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch),
        .o_addr  (addr_ch)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Parser model: position, nibble accumulator, form, separator, error
    // ------------------------------------------------------------------
    t_pos  str_pos;
    t_addr nib_acc;
    bit    joined_form;
    bit    dash_sep;
    bit    parse_err;

    t_addr_beat pending_addrs[$];   // expected address beats, oldest first
    int         mismatch_cnt;
    int         burst_left;

    // hex value of a character, -1 when it is not a hex digit
    function automatic int nibble_of(input t_char c);
        if (c >= CHAR_0 && c <= CHAR_9) begin
            return int'(c) - int'(CHAR_0);
        end
        if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
            return int'(c) - int'(CHAR_LC_A) + 10;
        end
        if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
            return int'(c) - int'(CHAR_UC_A) + 10;
        end
        return -1;
    endfunction

    // Advance the model by one character. On a last character it yields
    // the address beat and returns to the start-of-string state.
    task automatic parse_char(input t_char c, input logic last,
                              output bit has_res, output t_addr_beat res);
        t_pos p;
        int   nib;
        t_pos len;
        bit   ok;
        p       = str_pos;
        has_res = 1'b0;
        res     = '0;
        if (p == POS_FIRST_SEP && (c == CHAR_COLON || c == CHAR_DASH)) begin
            // the character at index 2 picks the joined form and its separator
            joined_form = 1'b1;
            dash_sep    = (c == CHAR_DASH);
        end else if (p < LEN_JOINED) begin
            if (joined_form && (p == POS_SEP_B || p == POS_SEP_C ||
                                p == POS_SEP_D || p == POS_SEP_E)) begin
                if (c != (dash_sep ? CHAR_DASH : CHAR_COLON)) begin
                    parse_err = 1'b1;
                end
            end else begin
                nib = nibble_of(c);
                if (nib < 0) begin
                    parse_err = 1'b1;
                end else begin
                    nib_acc = {nib_acc[ADDR_W-NIBBLE_W-1:0], t_nibble'(nib)};
                end
            end
        end
        // past index 16 nothing is checked; the length decides
        if (!last) begin
            if (str_pos != POS_MAX) begin
                str_pos = str_pos + t_pos'(1);
            end
        end else begin
            ok = 1'b0;
            if (!parse_err && p != POS_MAX) begin
                len = p + t_pos'(1);
                ok  = (!joined_form && len == LEN_PLAIN) ||
                      (joined_form && len == LEN_JOINED);
            end
            has_res       = 1'b1;
            res.address   = ok ? nib_acc : '0;
            res.valid_res = ok;
            str_pos     = '0;
            nib_acc     = '0;
            joined_form = 1'b0;
            dash_sep    = 1'b0;
            parse_err   = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Character sender: one beat, driven at the falling edge, accepted at
    // the rising edge where valid and ready are both high. Bursts of random
    // length, with idle gaps between them.
    // ------------------------------------------------------------------
    task automatic send_char(input t_char c, input logic last,
                             input bit typed, input t_addr_beat typed_res);
        bit         has_res;
        t_addr_beat res;
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        char_ch.last_char <= last;
        @(posedge i_clk);
        while (!char_ch.ready) @(posedge i_clk);
        parse_char(c, last, has_res, res);
        if (has_res) begin
            pending_addrs.push_back(typed ? typed_res : res);
        end
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // valid only drops here, and the next raise is a later edge
            char_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_text(input t_char_q s, input bit typed,
                             input t_addr_beat typed_res);
        for (int i = 0; i < s.size(); i++) begin
            send_char(s[i], i == s.size() - 1, typed, typed_res);
        end
    endtask

    function automatic t_char rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) begin
            return CHAR_0 + t_char'(v);
        end
        return ($urandom_range(0, 1) ? CHAR_UC_A : CHAR_LC_A) + t_char'(v - 10);
    endfunction

    // Random address text. Mostly well-formed strings with random digits;
    // the rest has one bad character, a wrong length, a wrong separator,
    // or is plain byte noise (up to 40 bytes, so the count can saturate).
    function automatic t_char_q random_address_text();
        t_char_q s;
        int      kind;
        int      idx;
        bit      joined;
        t_char   sep;
        kind = $urandom_range(0, 99);
        if (kind >= 90) begin
            repeat ($urandom_range(1, 40)) s.push_back(t_char'($urandom_range(0, 255)));
            return s;
        end
        joined = (kind < 40) || (kind >= 85) || (kind >= 60 && kind[0]);
        sep    = $urandom_range(0, 1) ? CHAR_DASH : CHAR_COLON;
        for (int i = 0; i < 6; i++) begin
            if (joined && i > 0) begin
                s.push_back(sep);
            end
            s.push_back(rand_hex_char());
            s.push_back(rand_hex_char());
        end
        if (kind >= 60 && kind < 75) begin
            // one corrupted character: any byte, a separator or a digit
            idx = $urandom_range(0, s.size() - 1);
            case ($urandom_range(0, 2))
                0: s[idx] = t_char'($urandom_range(0, 255));
                1: s[idx] = $urandom_range(0, 1) ? CHAR_DASH : CHAR_COLON;
                default: s[idx] = rand_hex_char();
            endcase
        end else if (kind >= 75 && kind < 85) begin
            if ($urandom_range(0, 1)) begin
                idx = $urandom_range(1, s.size() - 1);
                while (s.size() > idx) void'(s.pop_back());
            end else begin
                repeat ($urandom_range(1, 20)) begin
                    s.push_back($urandom_range(0, 3) == 0 ? sep : rand_hex_char());
                end
            end
        end else if (kind >= 85) begin
            // swap one separator for the other kind
            idx    = 2 + 3 * $urandom_range(0, 4);
            s[idx] = (s[idx] == CHAR_DASH) ? CHAR_COLON : CHAR_DASH;
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Directed strings: both forms, digit extremes in both cases, every
    // wrong length around 12 and 17, separator mismatches, bad digits at
    // the edges of the hex ranges, separators in the plain form, a high
    // byte, and overlong strings up to and past saturation.
    // ------------------------------------------------------------------
    t_dir_case dir_cases [N_DIR] = '{
        '{"00:11:22:33:44:55",                        1, 48'h0011_2233_4455, 1'b1},
        '{"ff-FF-aA-Bb-09-90",                        1, 48'hFFFF_AABB_0990, 1'b1},
        '{"1A2b3C4d5E6f",                             1, 48'h1A2B_3C4D_5E6F, 1'b1},
        '{"FFFFFFFFFFFF",                             1, 48'hFFFF_FFFF_FFFF, 1'b1},
        '{"000000000000",                             1, 48'h0,              1'b1},
        '{"9f-8E-7d-6C-5b-4A",                        0, 48'h0,              1'b0},
        '{"abcdefABCDEF",                             0, 48'h0,              1'b0},
        '{"0",                                        1, 48'h0,              1'b0},
        '{"1A2B3C4D5E6",                              1, 48'h0,              1'b0},
        '{"1A2B3C4D5E6F0",                            1, 48'h0,              1'b0},
        '{"00:11:22:33:44:5",                         1, 48'h0,              1'b0},
        '{"00:11:22:33:44:55:",                       1, 48'h0,              1'b0},
        '{"00:11-22:33:44:55",                        1, 48'h0,              1'b0},
        '{"00-11-22-33-44:55",                        1, 48'h0,              1'b0},
        '{"00:112233445566",                          1, 48'h0,              1'b0},
        '{"00:11:2G:33:44:55",                        1, 48'h0,              1'b0},
        '{"0/1@2G3`4g5:",                             1, 48'h0,              1'b0},
        '{"00112233445-",                             1, 48'h0,              1'b0},
        '{"0:0011223344",                             1, 48'h0,              1'b0},
        '{"AB:CD:EF:01:23:4\377",                     1, 48'h0,              1'b0},
        '{"0123456789abcdef0123456789ABCDE",          1, 48'h0,              1'b0},
        '{"0123456789abcdef0123456789ABCDEF",         1, 48'h0,              1'b0},
        '{"00:11:22:33:44:55:66:77:88:99:aa:bb:cc:d", 1, 48'h0,              1'b0}
    };

    // ------------------------------------------------------------------
    // Receiver: ready follows a 16-bit pattern rotated every cycle between
    // redraws, and redrawn when its epoch count runs out: free-running,
    // random, mostly stalled, or mostly open.
    // ------------------------------------------------------------------
    logic [15:0] rdy_pattern;
    int          rdy_epoch;

    always @(negedge i_clk) begin
        if (rdy_epoch == 0) begin
            case ($urandom_range(0, 3))
                0: rdy_pattern = '1;
                1: rdy_pattern = 16'($urandom);
                2: rdy_pattern = 16'($urandom & $urandom);
                default: rdy_pattern = 16'($urandom | $urandom);
            endcase
            rdy_epoch = 32;
        end else begin
            rdy_pattern = {rdy_pattern[0], rdy_pattern[15:1]};
            rdy_epoch--;
        end
        addr_ch.ready <= rdy_pattern[0];
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted address beat against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_addr_beat want;
        if (i_rst_n && addr_ch.valid && addr_ch.ready) begin
            if (pending_addrs.size() == 0) begin
                report_mismatch($sformatf("unexpected beat addr=%h valid_res=%b",
                                          addr_ch.address, addr_ch.valid_res));
            end else begin
                want = pending_addrs.pop_front();
                if (addr_ch.address !== want.address) begin
                    report_mismatch($sformatf("address got %h want %h",
                                              addr_ch.address, want.address));
                end
                if (addr_ch.valid_res !== want.valid_res) begin
                    report_mismatch($sformatf("valid_res got %b want %b",
                                              addr_ch.valid_res, want.valid_res));
                end
            end
        end
    end

    // Watchdog: too long without a beat on either channel ends the run.
    int idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (char_ch.valid && char_ch.ready) ||
            (addr_ch.valid && addr_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_char_q s;
        int      sent;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        char_ch.valid     = 1'b0;
        char_ch.char_code = '0;
        char_ch.last_char = 1'b0;
        addr_ch.ready     = 1'b0;
        rdy_pattern       = '1;
        rdy_epoch         = 0;
        idle_cycles       = 0;
        mismatch_cnt      = 0;
        burst_left        = 0;
        str_pos           = '0;
        nib_acc           = '0;
        joined_form       = 1'b0;
        dash_sep          = 1'b0;
        parse_err         = 1'b0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        sent = 0;
        foreach (dir_cases[i]) begin
            s.delete();
            for (int k = 0; k < dir_cases[i].text.len(); k++) begin
                s.push_back(dir_cases[i].text[k]);
            end
            send_text(s, dir_cases[i].typed,
                      '{address: dir_cases[i].address,
                        valid_res: dir_cases[i].valid_res});
            sent += s.size();
        end

        while (sent < ITEM_TARGET) begin
            s = random_address_text();
            send_text(s, 1'b0, '0);
            sent += s.size();
        end
        char_ch.valid <= 1'b0;

        // the watchdog bounds this wait if a result never shows up
        while (pending_addrs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
